// ===== rtl/stkc_pkg.sv =====
// ----------------------------------------------------------------------------
// stkc_pkg
// Shared types, command and status codes for the stack calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stkc_pkg;

    localparam int DATA_W          = 64;
    localparam int CMD_W           = 4;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STATUS_W        = 3;
    localparam int DEF_STACK_DEPTH = 64;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = DATA_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_DUP     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_DROP    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUB     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIV     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MUL     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_OR      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REM     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LESS    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_GREATER = 4'd10;
    localparam logic [CMD_W-1:0] CMD_EQUAL   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_FINISH  = 4'd12;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DIV_ZERO  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FIN_EMPTY = 3'd4;

    // What a stack cell loads on the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ABOVE,
        CELL_BELOW
    } cell_op_t;

    // Request to the multi-cycle arithmetic unit.
    typedef struct packed {
        logic start;
        logic is_mul;
        logic is_rem;
    } alu_req_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_OUT_W-1:0]   depth;
        logic [STATUS_W-1:0]      status;
        logic                     is_final;
    } out_item_t;

endpackage

// ===== rtl/stkc_cell.sv =====
// ----------------------------------------------------------------------------
// stkc_cell
// One stack entry: holds, takes its upper neighbor, or takes its lower one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkc_cell (
    input  logic                         aclk,
    input  stkc_pkg::cell_op_t           op,
    input  logic [stkc_pkg::DATA_W-1:0]  from_above,
    input  logic [stkc_pkg::DATA_W-1:0]  from_below,
    output logic [stkc_pkg::DATA_W-1:0]  value
);

    logic [stkc_pkg::DATA_W-1:0] value_reg;
    logic [stkc_pkg::DATA_W-1:0] value_next;

    always_comb begin
        unique case (op)
            stkc_pkg::CELL_ABOVE: value_next = from_above;
            stkc_pkg::CELL_BELOW: value_next = from_below;
            default:              value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/stkc_alu.sv =====
// ----------------------------------------------------------------------------
// stkc_alu
// Combinational binary operations plus a shared multi-cycle unit for
// multiply (one 32x32 multiplier, three passes) and divide / remainder
// (restoring, one quotient bit per cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkc_alu (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [stkc_pkg::CMD_W-1:0]   quick_cmd,
    input  logic [stkc_pkg::DATA_W-1:0]  opa,
    input  logic [stkc_pkg::DATA_W-1:0]  opb,
    output logic [stkc_pkg::DATA_W-1:0]  quick_result,
    input  stkc_pkg::alu_req_t           req,
    output logic                         done,
    output logic [stkc_pkg::DATA_W-1:0]  result
);

    localparam int DW    = stkc_pkg::DATA_W;
    localparam int HW    = DW / 2;
    localparam int CNT_W = $clog2(stkc_pkg::DIV_STEPS);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_FIX  = 2'd3;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
        magnitude = v[DW-1] ? ({DW{1'b0}} - v) : v;
    endfunction

    // b is the entry below the top (opb), a is the top (opa).
    always_comb begin
        unique case (quick_cmd)
            stkc_pkg::CMD_ADD:     quick_result = opb + opa;
            stkc_pkg::CMD_SUB:     quick_result = opb - opa;
            stkc_pkg::CMD_OR:      quick_result = opb | opa;
            stkc_pkg::CMD_LESS:
                quick_result = DW'($signed(opb) < $signed(opa));
            stkc_pkg::CMD_GREATER:
                quick_result = DW'($signed(opb) > $signed(opa));
            stkc_pkg::CMD_EQUAL:   quick_result = DW'(opb == opa);
            default:               quick_result = '0;
        endcase
    end

    logic [1:0]       a_state_reg, a_state_next;
    logic [CNT_W-1:0] cnt_reg,     cnt_next;
    logic             done_reg,    done_next;
    logic [DW-1:0]    acc_reg,     acc_next;
    logic [DW-1:0]    rem_reg,     rem_next;
    logic [DW-1:0]    quo_reg,     quo_next;
    logic [DW-1:0]    dvs_reg,     dvs_next;
    logic             neg_reg,     neg_next;
    logic             is_rem_reg,  is_rem_next;

    logic [HW-1:0]    mul_x, mul_y;
    logic [DW-1:0]    mul_p;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic [DW-1:0]    fix_val;

    // Multiplier operands per pass: lo*lo, lo(a)*hi(b), hi(a)*lo(b).
    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin
                mul_x = dvs_reg[HW-1:0];
                mul_y = quo_reg[HW-1:0];
            end
            2'd1: begin
                mul_x = dvs_reg[HW-1:0];
                mul_y = quo_reg[DW-1:HW];
            end
            default: begin
                mul_x = dvs_reg[DW-1:HW];
                mul_y = quo_reg[HW-1:0];
            end
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fix_val = is_rem_reg ? rem_reg : quo_reg;

    always_comb begin
        a_state_next = a_state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        neg_next     = neg_reg;
        is_rem_next  = is_rem_reg;
        unique case (a_state_reg)
            A_IDLE: begin
                if (req.start) begin
                    cnt_next    = '0;
                    is_rem_next = req.is_rem;
                    rem_next    = '0;
                    if (req.is_mul) begin
                        quo_next     = opb;
                        dvs_next     = opa;
                        a_state_next = A_MUL;
                    end else begin
                        quo_next     = magnitude(opb);
                        dvs_next     = magnitude(opa);
                        neg_next     = req.is_rem ? opb[DW-1] : (opb[DW-1] ^ opa[DW-1]);
                        a_state_next = A_DIV;
                    end
                end
            end
            A_MUL: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == '0) begin
                    acc_next = mul_p;
                end else begin
                    acc_next = acc_reg + {mul_p[HW-1:0], {HW{1'b0}}};
                end
                if (cnt_reg == CNT_W'(2)) begin
                    done_next    = 1'b1;
                    a_state_next = A_IDLE;
                end
            end
            A_DIV: begin
                cnt_next = cnt_reg + CNT_W'(1);
                // Restore when the trial subtraction goes negative.
                rem_next = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], ~diff[DW]};
                if (cnt_reg == CNT_W'(stkc_pkg::DIV_STEPS - 1)) begin
                    a_state_next = A_FIX;
                end
            end
            default: begin
                acc_next     = neg_reg ? ({DW{1'b0}} - fix_val) : fix_val;
                done_next    = 1'b1;
                a_state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_state_reg <= A_IDLE;
            cnt_reg     <= '0;
            done_reg    <= 1'b0;
        end else begin
            a_state_reg <= a_state_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
        end
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        is_rem_reg <= is_rem_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ===== rtl/stack_calculator_eval.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_eval
// Response: registered on acceptance for push, dup, drop, add, sub, or, compares,
//   finish, unused codes and errors; for mul (32x32 multiplier, three passes), div
//   and rem when the arithmetic unit finishes. Throughput: one other command per cycle
//   unless the output stalls; mul, div and rem hold off the input until their result is registered.
// Reset: synchronous, active low; clears the entry count, not the stack cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_calculator_eval #(
    parameter int STACK_DEPTH = stkc_pkg::DEF_STACK_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stkc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stkc_pkg::out_item_t m_data
);

    localparam int DW      = stkc_pkg::DATA_W;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] FULL_COUNT = DEPTH_W'(STACK_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                 state_reg,  state_next;
    logic [DEPTH_W-1:0]   count_reg,  count_next;
    logic                 m_valid_reg;
    stkc_pkg::out_item_t  m_data_reg;

    logic [DW-1:0]        cell_q [STACK_DEPTH];
    stkc_pkg::cell_op_t   op_top, op_rest;
    logic [DW-1:0]        top_load;

    logic                 accept;
    logic                 empty, full, has_two;
    logic                 load_out;
    logic [DW-1:0]        out_top;
    logic [stkc_pkg::STATUS_W-1:0] out_status;
    logic                 out_final;

    stkc_pkg::alu_req_t   alu_req;
    logic [DW-1:0]        quick_result;
    logic                 alu_done;
    logic [DW-1:0]        alu_result;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_COUNT);
    assign has_two = (count_reg >= DEPTH_W'(2));

    // Cell 0 is the top of stack; push shifts the row down, pop shifts it up.
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic [DW-1:0]      above_d;
            logic [DW-1:0]      below_d;
            stkc_pkg::cell_op_t cell_op;
            if (gi == 0) begin : g_top
                assign above_d = top_load;
                assign cell_op = op_top;
            end else begin : g_inner
                assign above_d = cell_q[gi-1];
                assign cell_op = op_rest;
            end
            if (gi == STACK_DEPTH - 1) begin : g_last
                assign below_d = cell_q[gi];
            end else begin : g_link
                assign below_d = cell_q[gi+1];
            end
            stkc_cell u_cell (
                .aclk       (aclk),
                .op         (cell_op),
                .from_above (above_d),
                .from_below (below_d),
                .value      (cell_q[gi])
            );
        end
    endgenerate

    stkc_alu u_alu (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .quick_cmd    (s_data.cmd),
        .opa          (cell_q[0]),
        .opb          (cell_q[1]),
        .quick_result (quick_result),
        .req          (alu_req),
        .done         (alu_done),
        .result       (alu_result)
    );

    always_comb begin
        op_top     = stkc_pkg::CELL_HOLD;
        op_rest    = stkc_pkg::CELL_HOLD;
        top_load   = quick_result;
        count_next = count_reg;
        state_next = state_reg;
        load_out   = 1'b0;
        out_top    = empty ? '0 : cell_q[0];
        out_status = stkc_pkg::STAT_OK;
        out_final  = 1'b0;
        alu_req    = '0;
        if (accept) begin
            load_out = 1'b1;
            unique case (s_data.cmd)
                stkc_pkg::CMD_PUSH: begin
                    if (full) begin
                        out_status = stkc_pkg::STAT_OVERFLOW;
                    end else begin
                        op_top     = stkc_pkg::CELL_ABOVE;
                        op_rest    = stkc_pkg::CELL_ABOVE;
                        top_load   = s_data.push_value;
                        count_next = count_reg + DEPTH_W'(1);
                        out_top    = s_data.push_value;
                    end
                end
                stkc_pkg::CMD_DUP: begin
                    if (empty) begin
                        out_status = stkc_pkg::STAT_UNDERFLOW;
                    end else if (full) begin
                        out_status = stkc_pkg::STAT_OVERFLOW;
                    end else begin
                        op_top     = stkc_pkg::CELL_ABOVE;
                        op_rest    = stkc_pkg::CELL_ABOVE;
                        top_load   = cell_q[0];
                        count_next = count_reg + DEPTH_W'(1);
                    end
                end
                stkc_pkg::CMD_DROP: begin
                    if (empty) begin
                        out_status = stkc_pkg::STAT_UNDERFLOW;
                    end else begin
                        op_top     = stkc_pkg::CELL_BELOW;
                        op_rest    = stkc_pkg::CELL_BELOW;
                        count_next = count_reg - DEPTH_W'(1);
                        out_top    = has_two ? cell_q[1] : '0;
                    end
                end
                stkc_pkg::CMD_ADD, stkc_pkg::CMD_SUB, stkc_pkg::CMD_OR,
                stkc_pkg::CMD_LESS, stkc_pkg::CMD_GREATER, stkc_pkg::CMD_EQUAL: begin
                    if (!has_two) begin
                        out_status = stkc_pkg::STAT_UNDERFLOW;
                    end else begin
                        op_top     = stkc_pkg::CELL_ABOVE;
                        op_rest    = stkc_pkg::CELL_BELOW;
                        count_next = count_reg - DEPTH_W'(1);
                        out_top    = quick_result;
                    end
                end
                stkc_pkg::CMD_MUL: begin
                    if (!has_two) begin
                        out_status = stkc_pkg::STAT_UNDERFLOW;
                    end else begin
                        alu_req.start  = 1'b1;
                        alu_req.is_mul = 1'b1;
                        load_out       = 1'b0;
                        state_next     = ST_BUSY;
                    end
                end
                stkc_pkg::CMD_DIV, stkc_pkg::CMD_REM: begin
                    if (!has_two) begin
                        out_status = stkc_pkg::STAT_UNDERFLOW;
                    end else if (cell_q[0] == '0) begin
                        out_status = stkc_pkg::STAT_DIV_ZERO;
                    end else begin
                        alu_req.start  = 1'b1;
                        alu_req.is_rem = (s_data.cmd == stkc_pkg::CMD_REM);
                        load_out       = 1'b0;
                        state_next     = ST_BUSY;
                    end
                end
                stkc_pkg::CMD_FINISH: begin
                    out_final = 1'b1;
                    if (empty) begin
                        out_status = stkc_pkg::STAT_FIN_EMPTY;
                    end else begin
                        count_next = '0;
                    end
                end
                default: begin
                    // Unused codes leave the stack alone.
                end
            endcase
        end else if (alu_done) begin
            // Retire mul/div/rem: replace the top two entries with the result.
            op_top     = stkc_pkg::CELL_ABOVE;
            op_rest    = stkc_pkg::CELL_BELOW;
            top_load   = alu_result;
            count_next = count_reg - DEPTH_W'(1);
            out_top    = alu_result;
            load_out   = 1'b1;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load_out) begin
            m_data_reg.top_value <= out_top;
            m_data_reg.depth     <= stkc_pkg::DEPTH_OUT_W'(count_next);
            m_data_reg.status    <= out_status;
            m_data_reg.is_final  <= out_final;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_done_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == ST_BUSY))
        else $error("arithmetic unit finished while no operation was pending");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUSY) |-> !s_ready)
        else $error("input taken while an operation is in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond stack capacity");

    a_finish_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.cmd == stkc_pkg::CMD_FINISH)) |=> (count_reg == '0))
        else $error("stack not empty after finish");

    a_out_free_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> !m_valid_reg)
        else $error("result register occupied when arithmetic unit retired");
`endif

endmodule
